// ----- design/rcrm_pkg.sv -----
package rcrm_pkg;

   localparam int POINTS = 1024;
   localparam int VALUE_BITS = 16;

   localparam int KIND_BITS = 2;
   localparam int LOW_BITS = 10;
   localparam int HIGH_BITS = 11;
   localparam int IN_VALUE_BITS = 16;
   localparam int OUT_VALUE_BITS = 16;

   localparam int LEVELS = $clog2(POINTS);
   localparam int LEAVES = 1 << LEVELS;
   localparam int NODES = 2 * LEAVES;
   localparam int NODE_BITS = LEVELS + 1;
   localparam int TREE_BITS = NODE_BITS + 1;
   localparam int LEVEL_BITS = $clog2(LEVELS + 1);
   localparam int ENTRY_BITS = VALUE_BITS + 1;
   localparam int WORD_BITS = 2 * ENTRY_BITS;

   typedef logic [ENTRY_BITS-1:0] entry_type;

   localparam entry_type EMPTY = entry_type'(1) << VALUE_BITS;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_CHMIN = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_APPLY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [LOW_BITS-1:0] range_low;
      logic [HIGH_BITS-1:0] range_high;
      logic [IN_VALUE_BITS-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic [OUT_VALUE_BITS-1:0] min_value;
      logic found;
   } status_type;

   function automatic entry_type min_entry(input entry_type a, input entry_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ----- design/rcrm_if.sv -----
interface rcrm_req_if;
   logic valid;
   logic ready;
   logic [rcrm_pkg::KIND_BITS-1:0] kind;
   logic [rcrm_pkg::LOW_BITS-1:0] range_low;
   logic [rcrm_pkg::HIGH_BITS-1:0] range_high;
   logic [rcrm_pkg::IN_VALUE_BITS-1:0] value;

   modport source (output valid, kind, range_low, range_high, value, input ready);
   modport sink (input valid, kind, range_low, range_high, value, output ready);
endinterface

interface rcrm_rsp_if;
   logic valid;
   logic ready;
   logic [rcrm_pkg::OUT_VALUE_BITS-1:0] min_value;
   logic found;

   modport source (output valid, min_value, found, input ready);
   modport sink (input valid, min_value, found, output ready);
endinterface

// ----- design/rcrm_ram.sv -----
module rcrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rcrm_engine.sv -----
module rcrm_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  rcrm_pkg::cmd_type     cmd,
   input  logic                  out_free,
   output rcrm_pkg::status_type  status
);

   rcrm_pkg::state_type state_ff, state_in;
   logic [rcrm_pkg::NODE_BITS-1:0] clr_ff, clr_in;
   logic is_query_ff, is_query_in;
   rcrm_pkg::entry_type x_ff, x_in;
   rcrm_pkg::entry_type acc_ff, acc_in;
   logic [rcrm_pkg::TREE_BITS-1:0] lc_ff, lc_in;
   logic [rcrm_pkg::TREE_BITS-1:0] rc_ff, rc_in;
   logic [rcrm_pkg::NODE_BITS-1:0] pa_ff, pa_in;
   logic [rcrm_pkg::NODE_BITS-1:0] pb_ff, pb_in;
   logic [rcrm_pkg::LEVEL_BITS-1:0] level_ff, level_in;
   logic [1:0] slot_ff, slot_in;
   logic [rcrm_pkg::NODE_BITS-1:0] node_ff, node_in;
   logic canon_ff, canon_in;

   logic ram_wr_en;
   logic [rcrm_pkg::NODE_BITS-1:0] ram_wr_addr;
   logic [rcrm_pkg::WORD_BITS-1:0] ram_wr_data;
   logic ram_rd_en;
   logic [rcrm_pkg::NODE_BITS-1:0] ram_rd_addr;
   logic [rcrm_pkg::WORD_BITS-1:0] ram_rd_data;

   logic [rcrm_pkg::HIGH_BITS-1:0] l_pos;
   logic [rcrm_pkg::HIGH_BITS-1:0] r_eff;
   logic range_empty;
   logic [rcrm_pkg::TREE_BITS-1:0] lc_start;
   logic [rcrm_pkg::TREE_BITS-1:0] rc_start;
   logic [rcrm_pkg::TREE_BITS-1:0] rc_last;
   logic [rcrm_pkg::TREE_BITS-1:0] rc_prev;
   logic live;
   logic slot_active;
   logic [rcrm_pkg::NODE_BITS-1:0] slot_node;
   rcrm_pkg::entry_type rd_tag;
   rcrm_pkg::entry_type rd_sub;
   logic advance;

   rcrm_ram #(
      .WIDTH(rcrm_pkg::WORD_BITS),
      .DEPTH(rcrm_pkg::NODES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcrm_pkg::ST_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
      is_query_ff <= is_query_in;
      x_ff <= x_in;
      acc_ff <= acc_in;
      lc_ff <= lc_in;
      rc_ff <= rc_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      level_ff <= level_in;
      slot_ff <= slot_in;
      node_ff <= node_in;
      canon_ff <= canon_in;
   end

   always_comb begin
      l_pos = rcrm_pkg::HIGH_BITS'(cmd.range_low);
      r_eff = (cmd.range_high > rcrm_pkg::HIGH_BITS'(rcrm_pkg::POINTS)) ?
              rcrm_pkg::HIGH_BITS'(rcrm_pkg::POINTS) : cmd.range_high;
      range_empty = (l_pos >= r_eff);
      lc_start = rcrm_pkg::TREE_BITS'(l_pos) + rcrm_pkg::TREE_BITS'(rcrm_pkg::LEAVES);
      rc_start = rcrm_pkg::TREE_BITS'(r_eff) + rcrm_pkg::TREE_BITS'(rcrm_pkg::LEAVES);
      rc_last = rc_start - rcrm_pkg::TREE_BITS'(1);
      rc_prev = rc_ff - rcrm_pkg::TREE_BITS'(1);
      live = (lc_ff < rc_ff);
      rd_tag = ram_rd_data[rcrm_pkg::WORD_BITS-1:rcrm_pkg::ENTRY_BITS];
      rd_sub = ram_rd_data[rcrm_pkg::ENTRY_BITS-1:0];

      case (slot_ff)
         2'd0: begin
            slot_active = live & lc_ff[0];
            slot_node = lc_ff[rcrm_pkg::NODE_BITS-1:0];
         end
         2'd1: begin
            slot_active = live & rc_ff[0];
            slot_node = rc_prev[rcrm_pkg::NODE_BITS-1:0];
         end
         2'd2: begin
            slot_active = 1'b1;
            slot_node = pa_ff;
         end
         default: begin
            slot_active = 1'b1;
            slot_node = pb_ff;
         end
      endcase

      state_in = state_ff;
      clr_in = clr_ff;
      is_query_in = is_query_ff;
      x_in = x_ff;
      acc_in = acc_ff;
      lc_in = lc_ff;
      rc_in = rc_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      level_in = level_ff;
      slot_in = slot_ff;
      node_in = node_ff;
      canon_in = canon_ff;
      ram_wr_en = 1'b0;
      ram_wr_addr = node_ff;
      ram_wr_data = {rcrm_pkg::EMPTY, rcrm_pkg::EMPTY};
      ram_rd_en = 1'b0;
      ram_rd_addr = slot_node;
      advance = 1'b0;
      status.idle = (state_ff == rcrm_pkg::ST_IDLE);
      status.done = 1'b0;
      status.found = (acc_ff != rcrm_pkg::EMPTY);
      status.min_value = status.found ?
                         rcrm_pkg::OUT_VALUE_BITS'(acc_ff[rcrm_pkg::VALUE_BITS-1:0]) : '0;

      unique case (state_ff)
         rcrm_pkg::ST_CLEAR: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in = clr_ff + rcrm_pkg::NODE_BITS'(1);
            if (clr_ff == '1) begin
               state_in = rcrm_pkg::ST_IDLE;
            end
         end
         rcrm_pkg::ST_IDLE: begin
            if (start) begin
               x_in = rcrm_pkg::entry_type'(cmd.value[rcrm_pkg::VALUE_BITS-1:0]);
               acc_in = rcrm_pkg::EMPTY;
               lc_in = lc_start;
               rc_in = rc_start;
               pa_in = lc_start[rcrm_pkg::NODE_BITS-1:0];
               pb_in = rc_last[rcrm_pkg::NODE_BITS-1:0];
               level_in = '0;
               slot_in = '0;
               case (cmd.kind)
                  rcrm_pkg::KIND_CHMIN: begin
                     is_query_in = 1'b0;
                     if (!range_empty) begin
                        state_in = rcrm_pkg::ST_ISSUE;
                     end
                  end
                  rcrm_pkg::KIND_QUERY: begin
                     is_query_in = 1'b1;
                     state_in = range_empty ? rcrm_pkg::ST_FINISH : rcrm_pkg::ST_ISSUE;
                  end
                  rcrm_pkg::KIND_CLEAR: begin
                     clr_in = '0;
                     state_in = rcrm_pkg::ST_CLEAR;
                  end
                  default: begin
                     state_in = rcrm_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         rcrm_pkg::ST_ISSUE: begin
            if (slot_active) begin
               ram_rd_en = 1'b1;
               node_in = slot_node;
               canon_in = ~slot_ff[1];
               state_in = rcrm_pkg::ST_APPLY;
            end else begin
               advance = 1'b1;
            end
         end
         rcrm_pkg::ST_APPLY: begin
            if (is_query_ff) begin
               acc_in = rcrm_pkg::min_entry(acc_ff, canon_ff ? rd_sub : rd_tag);
            end else begin
               ram_wr_en = 1'b1;
               ram_wr_data = {canon_ff ? rcrm_pkg::min_entry(rd_tag, x_ff) : rd_tag,
                              rcrm_pkg::min_entry(rd_sub, x_ff)};
            end
            state_in = rcrm_pkg::ST_ISSUE;
            advance = 1'b1;
         end
         rcrm_pkg::ST_FINISH: begin
            if (out_free) begin
               status.done = 1'b1;
               state_in = rcrm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rcrm_pkg::ST_IDLE;
         end
      endcase

      if (advance) begin
         state_in = rcrm_pkg::ST_ISSUE;
         if (slot_ff == 2'd3) begin
            if (level_ff == rcrm_pkg::LEVEL_BITS'(rcrm_pkg::LEVELS)) begin
               state_in = is_query_ff ? rcrm_pkg::ST_FINISH : rcrm_pkg::ST_IDLE;
            end
            lc_in = (lc_ff + rcrm_pkg::TREE_BITS'(lc_ff[0])) >> 1;
            rc_in = (rc_ff - rcrm_pkg::TREE_BITS'(rc_ff[0])) >> 1;
            pa_in = pa_ff >> 1;
            pb_in = pb_ff >> 1;
            level_in = level_ff + rcrm_pkg::LEVEL_BITS'(1);
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 2'd1;
         end
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("Store read and write in the same cycle.");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == rcrm_pkg::ST_APPLY |-> $past(state_ff) == rcrm_pkg::ST_ISSUE)
      else $error("Apply step without a preceding read.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcrm_pkg::ST_ISSUE || state_ff == rcrm_pkg::ST_APPLY) |->
      level_ff <= rcrm_pkg::LEVEL_BITS'(rcrm_pkg::LEVELS))
      else $error("Walk ran past the root.");

   assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == rcrm_pkg::ST_IDLE)
      else $error("Word accepted while the walk is busy.");
`endif

endmodule

// ----- design/range_chmin_range_min_tree.sv -----
// Range chmin and range minimum store over POINTS positions, kept as a segment tree of
// tag and subtree-minimum pairs in one single-port-read synchronous RAM. Each update or
// query climbs the tree from the leaves to the root, visiting up to four nodes per level
// (two boundary nodes of the range and two path nodes); each visited node is read in the
// issue state and modified or accumulated in the apply state, and a skipped node passes
// through the issue state alone. A query word then waits in the finish state until the
// output register is free to take its result. An empty-range update returns to idle
// straight away, and an empty-range query goes straight to the finish state. A clear word,
// and reset, sweep every node of the RAM one node per cycle, during which no word is
// accepted. A query result waits in an output register, so the next word can be taken
// while it is pending; updates and clears give no result.
module range_chmin_range_min_tree (
   input  logic         clock,
   input  logic         reset,
   rcrm_req_if.sink     req_port,
   rcrm_rsp_if.source   rsp_port
);

   rcrm_pkg::cmd_type cmd;
   rcrm_pkg::status_type status;
   logic start;
   logic out_free;
   logic rsp_valid_ff, rsp_valid_in;
   logic [rcrm_pkg::OUT_VALUE_BITS-1:0] rsp_min_ff, rsp_min_in;
   logic rsp_found_ff, rsp_found_in;

   rcrm_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .cmd      (cmd),
      .out_free (out_free),
      .status   (status)
   );

   always_comb begin
      cmd.kind = req_port.kind;
      cmd.range_low = req_port.range_low;
      cmd.range_high = req_port.range_high;
      cmd.value = req_port.value;
      req_port.ready = status.idle;
      start = req_port.valid & status.idle;
      out_free = ~rsp_valid_ff | rsp_port.ready;

      rsp_valid_in = rsp_valid_ff & ~rsp_port.ready;
      rsp_min_in = rsp_min_ff;
      rsp_found_in = rsp_found_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_min_in = status.min_value;
         rsp_found_in = status.found;
      end

      rsp_port.valid = rsp_valid_ff;
      rsp_port.min_value = rsp_min_ff;
      rsp_port.found = rsp_found_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_min_ff <= rsp_min_in;
      rsp_found_ff <= rsp_found_in;
   end

endmodule
